/* hw/rtl/zdfc_pkg.sv */
// Package for the zero-delimited frame collector.
// Holds the word types, status and register codes, and buffer sizing constants.
// Depends on nothing; every file of the collector imports it.
package zdfc_pkg;

    // Frame size limit and the buffer sizing that follows from it.
    localparam int FRAME_LIMIT = 510;
    localparam int BUF_DEPTH   = FRAME_LIMIT + 1;
    localparam int ADDR_W      = $clog2(BUF_DEPTH);
    // The fill count must hold FRAME_LIMIT + 1 for the overflow test.
    localparam int FILL_W      = $clog2(FRAME_LIMIT + 2);

    // Fixed field widths of the words.
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 9;
    localparam int INDEX_W     = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;

    // Delimiter value.
    localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

    // Operation codes of an input word.
    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    // Configuration register indexes and their reset values.
    localparam logic [CFG_IDX_W-1:0]  CFG_MIN_ACCEPT = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_MAX_ACCEPT = 1'b1;
    localparam logic [CFG_DATA_W-1:0] MIN_ACCEPT_RESET = 9'd12;
    localparam logic [CFG_DATA_W-1:0] MAX_ACCEPT_RESET = 9'd510;

    // Frame status reported with each result word.
    typedef enum logic [1:0] {
        STATUS_NONE     = 2'd0,
        STATUS_ACCEPT   = 2'd1,
        STATUS_REJECT   = 2'd2,
        STATUS_OVERFLOW = 2'd3
    } frame_status_t;

    // Input word.
    typedef struct packed {
        logic               operation;
        logic [BYTE_W-1:0]  rx_byte;
        logic [INDEX_W-1:0] read_index;
    } in_item_t;

    // Result word.
    typedef struct packed {
        frame_status_t      frame_status;
        logic [LEN_W-1:0]   frame_length;
        logic [BYTE_W-1:0]  read_data;
    } out_item_t;

endpackage

/* hw/rtl/zero_delimited_frame_collector.sv */
// Top level of the zero-delimited frame collector.
// Collects zero-delimited frames into a buffer and reports each closed frame.
// Depends on zdfc_pkg.
//
//   Channel   Direction  Handshake            Word
//   in        input      in_valid / in_ready    zdfc_pkg::in_item_t
//   out       output     out_valid / out_ready  zdfc_pkg::out_item_t
//   cfg       input      cfg_we (no wait)       cfg_index, cfg_data
//
// One word per cycle sustained while the receiver keeps out_ready high.
// The word sits in an input register, one pass of logic updates the fill count and the
// frame buffer's single write port, and the result register holds the answer.
// The input register takes a new word while a result waits in the output register only if it is empty.
// Reset clears the fill count, the handshake state and loads the register defaults;
// the frame buffer is not cleared and needs no clearing pass.
module zero_delimited_frame_collector (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  zdfc_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output zdfc_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [zdfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [zdfc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import zdfc_pkg::*;

    // Handshake and staging registers.
    logic                  in_valid_reg;
    in_item_t              in_item_reg;
    logic                  out_valid_reg;
    frame_status_t         out_status_reg;
    logic [LEN_W-1:0]      out_length_reg;
    logic                  rd_zero_reg;
    logic [BYTE_W-1:0]     mem_rdata_reg;

    // Frame state and configuration.
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;
    logic                  last_zero_reg;
    logic                  last_zero_next;
    logic [CFG_DATA_W-1:0] min_accept_reg;
    logic [CFG_DATA_W-1:0] max_accept_reg;

    // Frame buffer.
    logic [BYTE_W-1:0]     frame_mem [BUF_DEPTH];

    // Per-word logic.
    logic                  advance;
    logic                  take;
    logic                  is_rx;
    logic                  ch_zero;
    logic                  active;
    logic                  closed;
    logic                  in_window;
    logic [FILL_W-1:0]     pos;
    logic [FILL_W-1:0]     pos_inc;
    frame_status_t         status_next;
    logic [LEN_W-1:0]      length_next;
    logic                  rd_in_range;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;

    // The staged word moves on when the result register is free or being emptied.
    assign advance  = !out_valid_reg || out_ready;
    assign take     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_accept_reg <= MIN_ACCEPT_RESET;
            max_accept_reg <= MAX_ACCEPT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_ACCEPT: min_accept_reg <= cfg_data;
                CFG_MAX_ACCEPT: max_accept_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Decode of the staged word.
    assign is_rx   = (in_item_reg.operation == OP_RECEIVE);
    assign ch_zero = (in_item_reg.rx_byte == ZERO_BYTE);
    assign active  = is_rx && (ch_zero || (fill_reg != '0));

    // Frame tracking: store position, false start, overflow and close.
    always_comb
    begin
        pos            = fill_reg;
        closed         = 1'b0;
        status_next    = STATUS_NONE;
        length_next    = '0;
        fill_next      = fill_reg;
        last_zero_next = last_zero_reg;
        if (ch_zero && (fill_reg != '0))
        begin
            // A zero right after the opening zero restarts the frame at this zero.
            if (last_zero_reg)
            begin
                pos = fill_reg - 1'b1;
            end
            else
            begin
                closed = 1'b1;
            end
        end
        pos_inc   = pos + 1'b1;
        in_window = (32'(pos_inc) >= 32'(min_accept_reg))
                 && (32'(pos_inc) <= 32'(max_accept_reg));
        if (active)
        begin
            priority if (32'(pos_inc) > 32'(FRAME_LIMIT))
            begin
                fill_next   = '0;
                status_next = STATUS_OVERFLOW;
            end
            else if (closed)
            begin
                fill_next   = '0;
                length_next = LEN_W'(pos_inc);
                status_next = in_window ? STATUS_ACCEPT : STATUS_REJECT;
            end
            else
            begin
                fill_next      = pos_inc;
                last_zero_next = ch_zero;
            end
        end
    end

    assign wr_addr     = ADDR_W'(pos);
    assign rd_in_range = (32'(in_item_reg.read_index) < 32'(BUF_DEPTH));
    assign rd_addr     = ADDR_W'(in_item_reg.read_index);

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            last_zero_reg <= 1'b0;
        end
        else if (take)
        begin
            fill_reg      <= fill_next;
            last_zero_reg <= last_zero_next;
        end
    end

    // Frame buffer: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (take && active)
        begin
            frame_mem[wr_addr] <= in_item_reg.rx_byte;
        end
        if (take && !is_rx)
        begin
            mem_rdata_reg <= frame_mem[rd_addr];
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_status_reg <= status_next;
            out_length_reg <= length_next;
            rd_zero_reg    <= is_rx || !rd_in_range;
        end
    end

    // Output word.
    assign out_valid              = out_valid_reg;
    assign out_data.frame_status  = out_status_reg;
    assign out_data.frame_length  = out_length_reg;
    assign out_data.read_data     = rd_zero_reg ? ZERO_BYTE : mem_rdata_reg;

    // The open frame never holds more than the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= 32'(FRAME_LIMIT))
        else $error("fill count above frame limit");

    // Any reported frame event leaves no frame open.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && (status_next != STATUS_NONE)) |=> (fill_reg == '0))
        else $error("frame still open after close or overflow");

    // An accepted frame lies inside the configured window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == STATUS_ACCEPT)) |->
        ((out_length_reg >= min_accept_reg) && (out_length_reg <= max_accept_reg)))
        else $error("accepted frame outside length window");

    // Only a closed frame carries a length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_status_reg == STATUS_NONE)
                        || (out_status_reg == STATUS_OVERFLOW))) |->
        (out_length_reg == '0))
        else $error("length reported without a closed frame");

    // A frame event only comes from a receive word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != STATUS_NONE)) |-> rd_zero_reg)
        else $error("frame event on a read word");

endmodule

/* sim/zdfc_report_checker.sv */
`timescale 1ns / 1ps
// Result checker for the zero-delimited frame collector: watches both word channels
// and the register port, predicts each result word and compares it. Depends on zdfc_pkg.
module zdfc_report_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  zdfc_pkg::in_item_t              in_data,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  zdfc_pkg::out_item_t             out_data,
    input  logic                            cfg_we,
    input  logic [zdfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [zdfc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatch_count,
    output int                              reports_owed
);
    import zdfc_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Shadow of the collector: frame buffer, fill count and acceptance window.
    logic [BYTE_W-1:0] frame_mem [BUF_DEPTH];
    int unsigned       fill;
    int unsigned       min_len;
    int unsigned       max_len;

    // Result words that accepted input words still owe, oldest first.
    out_item_t         awaited_reports [$];
    int                mismatches;
    int                result_index;

    // Applies one input word to the shadow state and returns the result word it causes.
    function automatic out_item_t advance_collector(input in_item_t w);
        out_item_t r;
        logic      closing;
        r = '0;
        r.frame_status = STATUS_NONE;
        closing = 1'b0;
        if (w.operation == OP_READ)
        begin
            if (32'(w.read_index) < BUF_DEPTH)
            begin
                r.read_data = frame_mem[w.read_index];
            end
        end
        else if (w.rx_byte == ZERO_BYTE || fill != 0)
        begin
            // A zero inside a frame either restarts it after an opening zero or closes it.
            if (w.rx_byte == ZERO_BYTE && fill != 0)
            begin
                if (frame_mem[fill - 1] == ZERO_BYTE)
                begin
                    fill = fill - 1;
                end
                else
                begin
                    closing = 1'b1;
                end
            end
            if (fill < BUF_DEPTH)
            begin
                frame_mem[fill] = w.rx_byte;
            end
            fill = fill + 1;
            // A frame that outgrows the limit is dropped, even on its closing zero.
            if (fill > FRAME_LIMIT)
            begin
                fill = 0;
                closing = 1'b0;
                r.frame_status = STATUS_OVERFLOW;
            end
            if (closing)
            begin
                r.frame_length = LEN_W'(fill);
                if (fill >= min_len && fill <= max_len)
                begin
                    r.frame_status = STATUS_ACCEPT;
                end
                else
                begin
                    r.frame_status = STATUS_REJECT;
                end
                fill = 0;
            end
        end
        return r;
    endfunction

    // Register writes, result comparison and prediction, all on the pre-edge values.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            fill = 0;
            min_len = 32'(MIN_ACCEPT_RESET);
            max_len = 32'(MAX_ACCEPT_RESET);
            awaited_reports.delete();
            mismatches = 0;
            result_index = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MIN_ACCEPT)
                begin
                    min_len = 32'(cfg_data);
                end
                else if (cfg_index == CFG_MAX_ACCEPT)
                begin
                    max_len = 32'(cfg_data);
                end
            end

            if (out_valid && out_ready)
            begin
                if (awaited_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("ERROR: result word %0d arrived with none pending: ",
                                 result_index,
                                 "status %0d length %0d data 0x%02h",
                                 out_data.frame_status, out_data.frame_length,
                                 out_data.read_data);
                    end
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (out_data.frame_status !== want.frame_status ||
                        out_data.frame_length !== want.frame_length ||
                        out_data.read_data !== want.read_data)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("ERROR: result word %0d: ", result_index,
                                     "expected status %0d length %0d data 0x%02h, ",
                                     want.frame_status, want.frame_length,
                                     want.read_data,
                                     "got status %0d length %0d data 0x%02h",
                                     out_data.frame_status, out_data.frame_length,
                                     out_data.read_data);
                        end
                    end
                end
                result_index++;
            end

            if (in_valid && in_ready)
            begin
                awaited_reports.push_back(advance_collector(in_data));
            end
        end
        mismatch_count <= mismatches;
        reports_owed <= awaited_reports.size();
    end

endmodule

/* sim/tb_zero_delimited_frame_collector.sv */
`timescale 1ns / 1ps
// Top of the frame collector testbench: clock, reset, stimulus, idling and the verdict.
// Depends on zdfc_pkg, zero_delimited_frame_collector and zdfc_report_checker.
module tb_zero_delimited_frame_collector;
    import zdfc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_COUNT = 7;
    localparam int PHASE_ITEMS = 60;

    typedef enum int { RX_STEADY, RX_COIN, RX_STALLS, RX_TOGGLE } ready_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatch_count;
    int reports_owed;
    int cycle_count;
    int burst_left;
    int useful_items;

    zero_delimited_frame_collector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    zdfc_report_checker report_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .reports_owed   (reports_owed)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop if the run hangs.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver side: switches between steady, coin-flip, stall-burst and toggling modes.
    initial
    begin
        ready_mode_t mode;
        int          span;
        int          stall;
        out_ready = 1'b0;
        stall = 0;
        forever
        begin
            mode = ready_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    RX_STEADY: out_ready <= 1'b1;
                    RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
                    RX_STALLS:
                    begin
                        if (stall > 0)
                        begin
                            out_ready <= 1'b0;
                            stall--;
                        end
                        else
                        begin
                            out_ready <= 1'b1;
                            if ($urandom_range(0, 9) == 0)
                            begin
                                stall = $urandom_range(1, 16);
                            end
                        end
                    end
                    default:   out_ready <= ~out_ready;
                endcase
            end
        end
    end

    // A receive word; the unused index field carries junk.
    function automatic in_item_t rx_word(input logic [BYTE_W-1:0] value);
        in_item_t w;
        w.operation = OP_RECEIVE;
        w.rx_byte = value;
        w.read_index = INDEX_W'($urandom_range(0, 511));
        return w;
    endfunction

    // A buffer read word; the unused byte field carries junk.
    function automatic in_item_t read_word(input logic [INDEX_W-1:0] index);
        in_item_t w;
        w.operation = OP_READ;
        w.rx_byte = BYTE_W'($urandom_range(0, 255));
        w.read_index = index;
        return w;
    endfunction

    // Offers one word and returns at the edge that takes it, with valid still high.
    // Bursts of back-to-back words are separated by random gaps.
    task automatic send_word(input in_item_t w);
        bit taken;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            if ($urandom_range(0, 5) == 0)
            begin
                burst_left = $urandom_range(50, 200);
            end
            else
            begin
                burst_left = $urandom_range(1, 12);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= w;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // One frame: opening zero, optional false starts, nonzero content with some reads
    // mixed in, and a closing zero.
    task automatic send_frame(input int content_len, input int false_starts);
        send_word(rx_word(ZERO_BYTE));
        repeat (false_starts) send_word(rx_word(ZERO_BYTE));
        repeat (content_len)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_word(read_word(INDEX_W'($urandom_range(0, 511))));
                useful_items++;
            end
            send_word(rx_word(BYTE_W'($urandom_range(1, 255))));
        end
        send_word(rx_word(ZERO_BYTE));
        useful_items += content_len + false_starts + 2;
    endtask

    // Stops sending and waits until every owed result word has come back.
    task automatic drain_collector();
        in_valid <= 1'b0;
        burst_left = 0;
        do
        begin
            @(posedge clk);
        end
        while (reports_owed != 0);
        repeat (8) @(posedge clk);
    endtask

    // Writes both ends of the acceptance window on consecutive edges.
    task automatic write_window(input int lo, input int hi);
        cfg_we <= 1'b1;
        cfg_index <= CFG_MIN_ACCEPT;
        cfg_data <= CFG_DATA_W'(lo);
        @(posedge clk);
        cfg_index <= CFG_MAX_ACCEPT;
        cfg_data <= CFG_DATA_W'(hi);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Main stimulus.
    initial
    begin
        int lo;
        int hi;
        int pick;
        int phase;
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_MIN_ACCEPT;
        cfg_data = '0;
        burst_left = 0;
        useful_items = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // An overlong frame stores a byte in every buffer entry and overflows on its
        // closing zero, so that any later read sees written data.
        send_word(rx_word(ZERO_BYTE));
        repeat (FRAME_LIMIT - 1) send_word(rx_word(BYTE_W'($urandom_range(1, 255))));
        send_word(rx_word(ZERO_BYTE));

        // Reads at both ends of the buffer and one past it.
        send_word(read_word(INDEX_W'(0)));
        send_word(read_word(INDEX_W'(FRAME_LIMIT)));
        send_word(read_word(INDEX_W'(511)));
        // A stray byte outside a frame is dropped.
        send_word(rx_word(8'hFF));
        // False start, then a short frame that the reset window rejects.
        send_word(rx_word(ZERO_BYTE));
        send_word(rx_word(ZERO_BYTE));
        send_word(rx_word(8'hFF));
        send_word(rx_word(8'h01));
        send_word(rx_word(ZERO_BYTE));
        send_word(read_word(INDEX_W'(0)));
        send_word(read_word(INDEX_W'(2)));
        send_word(rx_word(8'h80));
        // A frame of exactly the reset minimum length, walking a one through the byte.
        send_word(rx_word(ZERO_BYTE));
        for (k = 0; k < BYTE_W; k++)
        begin
            send_word(rx_word(BYTE_W'(1 << k)));
        end
        send_word(rx_word(8'hAA));
        send_word(rx_word(8'h55));
        send_word(rx_word(ZERO_BYTE));

        // Random traffic under a series of acceptance windows.
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase > 0)
            begin
                case (phase)
                    1:       begin lo = 1;   hi = 511; end
                    2:       begin lo = 511; hi = 1;   end
                    3:       begin lo = 3;   hi = 3;   end
                    4:       begin lo = 5;   hi = 20;  end
                    5:       begin lo = 510; hi = 510; end
                    default:
                    begin
                        lo = $urandom_range(1, 30);
                        hi = $urandom_range(1, 60);
                    end
                endcase
                drain_collector();
                write_window(lo, hi);
            end
            useful_items = 0;

            while (useful_items < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    k = $urandom_range(0, 19);
                    if (k == 0)
                    begin
                        send_frame(0, 0);
                    end
                    else if (k < 3)
                    begin
                        send_frame($urandom_range(60, 200), 0);
                    end
                    else
                    begin
                        send_frame($urandom_range(1, 25),
                                   ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
                    end
                end
                else if (pick < 85)
                begin
                    send_word(read_word(INDEX_W'($urandom_range(0, 511))));
                    useful_items++;
                end
                else if (pick < 95)
                begin
                    repeat ($urandom_range(1, 4))
                        send_word(rx_word(BYTE_W'($urandom_range(1, 255))));
                end
                else
                begin
                    send_word(rx_word(BYTE_W'($urandom_range(0, 255))));
                    useful_items++;
                end
            end
        end

        drain_collector();
        if (mismatch_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/zdfc_pkg.sv
hw/rtl/zero_delimited_frame_collector.sv
sim/zdfc_report_checker.sv
sim/tb_zero_delimited_frame_collector.sv
